### src/bmp8_indexed_stream_decoder_unit_defines.svh
// Assertion macros for the decoder RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef BMP8_INDEXED_STREAM_DECODER_UNIT_DEFINES_SVH
`define BMP8_INDEXED_STREAM_DECODER_UNIT_DEFINES_SVH

// Immediate-consequence check under synchronous reset
`define BMP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// Next-cycle consequence check
`define BMP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

### src/bmp8_pkg.sv
// Shared types and constants for the 8-bit indexed bitmap decoder.
// No dependencies.
`timescale 1ns / 1ps
package bmp8_pkg;
    localparam int MaxWidth  = 4096;
    localparam int MaxHeight = 4096;
    localparam int QDepth    = 4;
    localparam int QAw       = $clog2(QDepth);

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_SKIP   = 2'd1,
        PH_PIXEL  = 2'd2,
        PH_DRAIN  = 2'd3
    } t_phase;

    typedef enum logic [3:0] {
        E_SIG = 4'd0, E_SMALL = 4'd1, E_TRUNC_HDR = 4'd2, E_WIDTH = 4'd3,
        E_HEIGHT = 4'd4, E_PLANES = 4'd5, E_DEPTH = 4'd6, E_COMPR = 4'd7,
        E_PAL = 4'd8, E_OFFSET = 4'd9, E_TRUNC_PIX = 4'd10, E_LARGE = 4'd11
    } t_err;

    // Command from front to back: classified byte plus geometry.
    typedef struct packed {
        logic        is_err;
        t_err        code;
        logic        is_pix;    // pixel byte
        logic        last;
        logic [7:0]  value;
        logic        first;     // first pixel-region byte: restart counters
        logic [12:0] w;
        logic [12:0] h;
        logic        top;
    } t_cmd;

    typedef struct packed {
        logic        kind;
        logic [7:0]  pix;
        logic [11:0] col;
        logic [11:0] row;
        logic        fin;
        t_err        code;
        logic [12:0] w;
        logic [12:0] h;
        logic        top;
    } t_res;
endpackage

### src/bmp8_front.sv
// Front end: header assembly, checks, offset skip; emits commands.
// Depends on bmp8_pkg.
`timescale 1ns / 1ps
module bmp8_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_byte,
    input  logic            i_last,
    output logic            o_cmd_valid,
    output bmp8_pkg::t_cmd  o_cmd
);
    bmp8_pkg::t_phase r_ph, n_ph;
    logic [31:0] r_pos, r_start, r_hlen, r_w, r_h, r_pd, r_comp, r_cc;
    logic [7:0]  r_sig;
    logic        r_first;
    logic [31:0] habs;
    logic [33:0] need;
    logic [8:0]  pal;
    logic        hdr_err;
    bmp8_pkg::t_err hdr_code;
    bmp8_pkg::t_cmd cmd;
    logic        cv;
    logic [1:0]  lane;

    assign habs = r_h[31] ? (~r_h + 32'd1) : r_h;
    assign pal  = (r_cc == 32'd0) ? 9'd256 : r_cc[8:0];
    // Every field starts at a position of 2 mod 4, so this is its byte lane.
    assign lane = r_pos[1:0] - 2'd2;

    // Checks at byte 53; the colour count byte 49 is the last field byte.
    always_comb begin
        need = 34'd14 + {2'b00, r_hlen} + {23'd0, pal, 2'b00};
        hdr_err  = 1'b1;
        hdr_code = bmp8_pkg::E_WIDTH;
        if (r_w == 32'd0 || r_w[31]) hdr_code = bmp8_pkg::E_WIDTH;
        else if (r_h == 32'd0) hdr_code = bmp8_pkg::E_HEIGHT;
        else if (r_pd[15:0] != 16'd1) hdr_code = bmp8_pkg::E_PLANES;
        else if (r_pd[31:16] != 16'd8) hdr_code = bmp8_pkg::E_DEPTH;
        else if (r_comp != 32'd0) hdr_code = bmp8_pkg::E_COMPR;
        else if (r_cc > 32'd256) hdr_code = bmp8_pkg::E_PAL;
        else if ({2'b00, r_start} < need) hdr_code = bmp8_pkg::E_OFFSET;
        else if (r_w > 32'(bmp8_pkg::MaxWidth) || habs > 32'(bmp8_pkg::MaxHeight))
            hdr_code = bmp8_pkg::E_LARGE;
        else hdr_err = 1'b0;
    end

    always_comb begin
        n_ph = r_ph;
        cv   = 1'b0;
        cmd  = '0;
        cmd.last  = i_last;
        cmd.value = i_byte;
        cmd.w     = r_w[12:0];
        cmd.h     = habs[12:0];
        cmd.top   = r_h[31];
        cmd.first = r_first;
        if (i_valid) begin
            unique case (r_ph)
                bmp8_pkg::PH_HEADER: begin
                    if (r_pos == 32'd1 && {i_byte, r_sig} != 16'h4D42) begin
                        cv = 1'b1; cmd.is_err = 1'b1; cmd.code = bmp8_pkg::E_SIG;
                    end else if (r_pos == 32'd17 && {i_byte, r_hlen[23:0]} < 32'd40) begin
                        cv = 1'b1; cmd.is_err = 1'b1; cmd.code = bmp8_pkg::E_SMALL;
                    end else if (r_pos == 32'd53) begin
                        if (hdr_err) begin
                            cv = 1'b1; cmd.is_err = 1'b1; cmd.code = hdr_code;
                        end else if (i_last) begin
                            cv = 1'b1; cmd.is_err = 1'b1;
                            cmd.code = (r_start > 32'd54) ? bmp8_pkg::E_OFFSET
                                                          : bmp8_pkg::E_TRUNC_PIX;
                        end else n_ph = bmp8_pkg::PH_SKIP;
                    end else if (i_last) begin
                        cv = 1'b1; cmd.is_err = 1'b1;
                        cmd.code = (r_pos == 32'd0) ? bmp8_pkg::E_SIG
                                                    : bmp8_pkg::E_TRUNC_HDR;
                    end
                    if (cv) n_ph = bmp8_pkg::PH_DRAIN;
                end
                bmp8_pkg::PH_SKIP: begin
                    if (r_pos < r_start) begin
                        if (i_last) begin
                            cv = 1'b1; cmd.is_err = 1'b1;
                            cmd.code = (r_start > r_pos + 32'd1) ? bmp8_pkg::E_OFFSET
                                                                 : bmp8_pkg::E_TRUNC_PIX;
                        end
                    end else begin
                        cv = 1'b1; cmd.is_pix = 1'b1; n_ph = bmp8_pkg::PH_PIXEL;
                    end
                end
                bmp8_pkg::PH_PIXEL: begin
                    cv = 1'b1; cmd.is_pix = 1'b1;
                end
                default: ;
            endcase
            if (i_last) n_ph = bmp8_pkg::PH_HEADER;
        end
    end

    assign o_cmd_valid = cv;
    assign o_cmd       = cmd;

    // Field assembly; hold a byte lane only inside its field window.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= bmp8_pkg::PH_HEADER;
            r_pos <= '0; r_start <= '0; r_hlen <= '0; r_w <= '0; r_h <= '0;
            r_pd <= '0; r_comp <= '0; r_cc <= '0; r_sig <= '0; r_first <= 1'b1;
        end else begin
            r_ph <= n_ph;
            if (i_valid) begin
                if (i_last) begin
                    r_pos <= '0; r_start <= '0; r_hlen <= '0; r_w <= '0; r_h <= '0;
                    r_pd <= '0; r_comp <= '0; r_cc <= '0; r_first <= 1'b1;
                end else begin
                    if (r_pos != 32'hFFFF_FFFF) r_pos <= r_pos + 32'd1;
                    if (r_ph == bmp8_pkg::PH_HEADER) begin
                        if (r_pos == 32'd0) r_sig <= i_byte;
                        if (r_pos >= 32'd10 && r_pos < 32'd14)
                            r_start[8*lane +: 8] <= i_byte;
                        if (r_pos >= 32'd14 && r_pos < 32'd18)
                            r_hlen[8*lane +: 8] <= i_byte;
                        if (r_pos >= 32'd18 && r_pos < 32'd22)
                            r_w[8*lane +: 8] <= i_byte;
                        if (r_pos >= 32'd22 && r_pos < 32'd26)
                            r_h[8*lane +: 8] <= i_byte;
                        if (r_pos >= 32'd26 && r_pos < 32'd30)
                            r_pd[8*lane +: 8] <= i_byte;
                        if (r_pos >= 32'd30 && r_pos < 32'd34)
                            r_comp[8*lane +: 8] <= i_byte;
                        if (r_pos >= 32'd46 && r_pos < 32'd50)
                            r_cc[8*lane +: 8] <= i_byte;
                    end
                    if (cv && cmd.is_pix) r_first <= 1'b0;
                end
            end
        end
    end
endmodule

### src/bmp8_queue.sv
// Short command queue between front and back ends.
// Depends on bmp8_pkg.
`timescale 1ns / 1ps
`include "bmp8_indexed_stream_decoder_unit_defines.svh"
module bmp8_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bmp8_pkg::t_cmd  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output bmp8_pkg::t_cmd  o_data
);
    bmp8_pkg::t_cmd r_mem [bmp8_pkg::QDepth];
    logic [bmp8_pkg::QAw-1:0] r_wp, r_rp;
    logic [bmp8_pkg::QAw:0]   r_cnt;
    logic do_push, do_pop;

    assign o_full  = (r_cnt == (bmp8_pkg::QAw+1)'(bmp8_pkg::QDepth));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (bmp8_pkg::QAw+1)'(do_push) - (bmp8_pkg::QAw+1)'(do_pop);
        end
    end

    `BMP_ASSERT_IMP(a_q_bound, i_clk, i_rst_n, 1'b1,
        r_cnt <= (bmp8_pkg::QAw+1)'(bmp8_pkg::QDepth))
    `BMP_ASSERT_NXT(a_q_fill, i_clk, i_rst_n, do_push && !do_pop,
        r_cnt == $past(r_cnt) + 1'b1)
    `BMP_ASSERT_NXT(a_q_drain, i_clk, i_rst_n, do_pop && !do_push,
        r_cnt == $past(r_cnt) - 1'b1)
endmodule

### src/bmp8_back.sv
// Back end: pixel column/row tracking, padding drop, result register.
// Depends on bmp8_pkg.
`timescale 1ns / 1ps
module bmp8_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  bmp8_pkg::t_cmd  i_cmd,
    output logic            o_take,
    output logic            o_empty,
    input  logic            i_pop,
    output bmp8_pkg::t_res  o_res
);
    logic [13:0] r_rbc;
    logic [11:0] r_frc;
    logic        r_drain, r_valid;
    bmp8_pkg::t_res r_res, res;
    logic [13:0] stride, rbc_inc;
    logic        emit, fin, gen;
    logic [11:0] hm1;

    assign o_take  = !i_empty && (!r_valid || i_pop);
    assign o_empty = !r_valid;
    assign o_res   = r_res;
    assign stride  = {1'b0, i_cmd.w} + 14'd3 & ~14'd3;
    assign hm1     = 12'(i_cmd.h - 13'd1);

    always_comb begin
        logic [13:0] rbc;
        logic [11:0] frc;
        rbc = i_cmd.first ? 14'd0 : r_rbc;
        frc = i_cmd.first ? 12'd0 : r_frc;
        res = '0;
        emit = 1'b0;
        fin  = 1'b0;
        rbc_inc = rbc + 14'd1;
        if (i_cmd.is_err) begin
            res.kind = 1'b1; res.code = i_cmd.code; emit = 1'b1;
        end else if (i_cmd.is_pix && !(r_drain && !i_cmd.first)) begin
            if (rbc < {1'b0, i_cmd.w}) begin
                fin = (frc == hm1) && (rbc == {1'b0, i_cmd.w} - 14'd1);
                emit = 1'b1;
                res.pix = i_cmd.value;
                res.col = rbc[11:0];
                res.row = i_cmd.top ? frc : (hm1 - frc);
                res.fin = fin;
                res.w = i_cmd.w; res.h = i_cmd.h; res.top = i_cmd.top;
            end
            if (!fin && i_cmd.last) begin
                res = '0; res.kind = 1'b1; res.code = bmp8_pkg::E_TRUNC_PIX; emit = 1'b1;
            end
        end
        gen = emit;
    end

    always_ff @(posedge i_clk) begin
        if (o_take) r_res <= res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rbc <= '0; r_frc <= '0; r_drain <= 1'b0; r_valid <= 1'b0;
        end else begin
            if (o_take) r_valid <= gen;
            else if (i_pop && r_valid) r_valid <= 1'b0;
            if (o_take) begin
                if (i_cmd.is_pix) begin
                    if (rbc_inc >= stride) begin
                        r_rbc <= '0;
                        r_frc <= (i_cmd.first ? 12'd0 : r_frc) + 12'd1;
                    end else begin
                        r_rbc <= rbc_inc;
                        if (i_cmd.first) r_frc <= '0;
                    end
                end
                if (i_cmd.last) r_drain <= 1'b0;
                else if (i_cmd.is_pix && res.fin) r_drain <= 1'b1;
                else if (i_cmd.first) r_drain <= 1'b0;
            end
        end
    end
endmodule

### src/bmp8_indexed_stream_decoder_unit.sv
// Top level of the 8-bit indexed bitmap stream decoder.
// Depends on bmp8_pkg, bmp8_front, bmp8_queue, bmp8_back.
//
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+-------------------------------
//  bytes     | in        | push / full        | i_byte_value, i_last_byte
//  results   | out       | empty / pop        | o_result_kind .. o_top_down
//
// One byte per cycle sustained while full is low; each result is registered in the back end.
// The front end classifies every byte in its accept cycle; the queue absorbs
// result-side stalls, and full rises only when it holds four commands.
// Reset is synchronous, active low, and rearms the parser for a new file.
`timescale 1ns / 1ps
module bmp8_indexed_stream_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_byte_value,
    input  logic        i_last_byte,
    output logic        empty,
    input  logic        pop,
    output logic        o_result_kind,
    output logic [7:0]  o_pixel_index,
    output logic [11:0] o_column,
    output logic [11:0] o_row,
    output logic        o_final_pixel,
    output logic [3:0]  o_error_code,
    output logic [12:0] o_image_width,
    output logic [12:0] o_image_height,
    output logic        o_top_down
);
    logic           acc, cmd_v, q_empty, take;
    bmp8_pkg::t_cmd cmd, q_cmd;
    bmp8_pkg::t_res res;

    // Accept a request whenever the queue has room.
    assign acc = push && !full;

    // Bytes after the final pixel keep flowing to the back end, which drops
    // them up to and including the last byte of the file.
    bmp8_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(acc),
        .i_byte(i_byte_value), .i_last(i_last_byte),
        .o_cmd_valid(cmd_v), .o_cmd(cmd)
    );

    bmp8_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(cmd_v && acc), .i_data(cmd),
        .o_full(full), .i_pop(take), .o_empty(q_empty), .o_data(q_cmd)
    );

    bmp8_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(q_empty), .i_cmd(q_cmd),
        .o_take(take), .o_empty(empty), .i_pop(pop), .o_res(res)
    );

    assign o_result_kind  = res.kind;
    assign o_pixel_index  = res.pix;
    assign o_column       = res.col;
    assign o_row          = res.row;
    assign o_final_pixel  = res.fin;
    assign o_error_code   = res.code;
    assign o_image_width  = res.w;
    assign o_image_height = res.h;
    assign o_top_down     = res.top;
endmodule
